// ===== hdl/compandor_gain_computer_unit_macros.svh =====
// Assertion helpers used by the compandor gain computer controller.
`ifndef COMPANDOR_GAIN_COMPUTER_UNIT_MACROS_SVH
`define COMPANDOR_GAIN_COMPUTER_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CGC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cgc_pkg.sv =====
package cgc_pkg;

  localparam int LOG_TABLE_BITS_DEF = 8;
  localparam int AMP_BITS = 16;

  localparam logic [16:0] ONE_Q16         = 17'd65536;
  localparam logic [31:0] LOW_LEVEL_LIMIT = 32'd21474;
  localparam logic [16:0] LOW_RISE        = 17'd6554;
  localparam logic [16:0] LOW_FALL        = 17'd19661;
  localparam logic [16:0] GAIN_RISE       = 17'd45875;
  localparam logic [16:0] GAIN_FALL       = 17'd26214;
  localparam logic [15:0] GAIN_RESET      = 16'd4096;
  localparam logic [4:0]  SQRT_LAST       = 5'(AMP_BITS - 1);

  typedef enum logic [1:0] {
    REGION_COMPRESS = 2'd0,
    REGION_EXPAND   = 2'd1,
    REGION_FLAT     = 2'd2,
    REGION_CONCEAL  = 2'd3
  } region_t;

  typedef enum logic [2:0] {
    IDX_LEVEL_RISE  = 3'd0,
    IDX_LEVEL_FALL  = 3'd1,
    IDX_UPPER_THR   = 3'd2,
    IDX_LOWER_THR   = 3'd3,
    IDX_UPPER_RATIO = 3'd4,
    IDX_LOWER_RATIO = 3'd5,
    IDX_CONCEAL     = 3'd6,
    IDX_MOD_GAIN    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] level_rise_coef;
    logic [16:0] level_fall_coef;
    logic [15:0] upper_threshold;
    logic [15:0] lower_threshold;
    logic [14:0] upper_ratio;
    logic [14:0] lower_ratio;
    logic [15:0] conceal_level;
    logic [15:0] moderate_gain;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       lvl_a;
    logic       lvl_b;
    logic       sqrt_step;
    logic       sel;
    logic       log_step;
    logic       den_init;
    logic       exp_init;
    logic       exp_step;
    logic       value;
    logic       shift;
    logic       gm_a;
    logic       gm_b;
    logic [4:0] idx;
  } cmd_t;

  // Elaboration-time integer square root, used only to build the root table.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] x;
    res = 64'd0;
    bit_v = 64'd1 << 62;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > x) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (x >= res + bit_v) begin
          x = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Q30 value of 2^(2^-k), truncated the same way at every level.
  function automatic logic [30:0] exp_root(int k);
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int j = 2; j <= k; j++) r = isqrt64(r << 30);
    return r[30:0];
  endfunction

  function automatic logic [3:0] msb16(logic [15:0] x);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (x[i]) p = 4'(i);
    end
    return p;
  endfunction

endpackage

// ===== hdl/cgc_controller.sv =====
`include "compandor_gain_computer_unit_macros.svh"

module cgc_controller #(
  parameter int LOG_TABLE_BITS = cgc_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output cgc_pkg::cmd_t cmd
);

  localparam logic [4:0] LOG_LAST = 5'(LOG_TABLE_BITS - 1);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_LVL_A = 14'b00000000000010,
    ST_LVL_B = 14'b00000000000100,
    ST_SQRT  = 14'b00000000001000,
    ST_SEL   = 14'b00000000010000,
    ST_LOG_N = 14'b00000000100000,
    ST_DEN   = 14'b00000001000000,
    ST_LOG_D = 14'b00000010000000,
    ST_EXP_I = 14'b00000100000000,
    ST_EXP   = 14'b00001000000000,
    ST_VAL   = 14'b00010000000000,
    ST_SHIFT = 14'b00100000000000,
    ST_GM_A  = 14'b01000000000000,
    ST_GM_B  = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.idx = cnt;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_LVL_A;
        end
      end
      ST_LVL_A: begin
        cmd.lvl_a = 1'b1;
        state_next = ST_LVL_B;
      end
      ST_LVL_B: begin
        cmd.lvl_b = 1'b1;
        cnt_next = 5'd0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == cgc_pkg::SQRT_LAST) state_next = ST_SEL;
      end
      ST_SEL: begin
        cmd.sel = 1'b1;
        cnt_next = 5'd0;
        state_next = ST_LOG_N;
      end
      ST_LOG_N: begin
        cmd.log_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == LOG_LAST) state_next = ST_DEN;
      end
      ST_DEN: begin
        cmd.den_init = 1'b1;
        cnt_next = 5'd0;
        state_next = ST_LOG_D;
      end
      ST_LOG_D: begin
        cmd.log_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == LOG_LAST) state_next = ST_EXP_I;
      end
      ST_EXP_I: begin
        cmd.exp_init = 1'b1;
        cnt_next = 5'd0;
        state_next = ST_EXP;
      end
      ST_EXP: begin
        cmd.exp_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == LOG_LAST) state_next = ST_VAL;
      end
      ST_VAL: begin
        cmd.value = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        state_next = ST_GM_A;
      end
      ST_GM_A: begin
        cmd.gm_a = 1'b1;
        state_next = ST_GM_B;
      end
      ST_GM_B: begin
        // The gain state and the output register update together, so wait
        // until the previous result has left.
        if (!out_valid || out_ready) begin
          cmd.gm_b = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.gm_b) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `CGC_ASSERT_NEXT(a_result_shown, clk, rst, cmd.gm_b, out_valid, "result not presented")
  `CGC_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid, "result lost")
  `CGC_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.gm_b, !out_valid || out_ready,
                   "pending result overwritten")
  `CGC_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ST_LVL_A,
                   "accepted transaction did not start")

endmodule

// ===== hdl/cgc_datapath.sv =====
module cgc_datapath #(
  parameter int LOG_TABLE_BITS = cgc_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cgc_pkg::cmd_t cmd,
  input  cgc_pkg::cfg_t cfg,
  input  logic [31:0]   energy_in,
  output logic [15:0]   gain_out,
  output logic [1:0]    gain_region
);

  localparam int F  = LOG_TABLE_BITS;
  localparam int LR = F + 4;
  localparam int DW = LR + 1;
  localparam int PW = DW + 16;
  localparam int NW = PW - 12 - F;

  logic [30:0] root_tab [F];
  for (genvar k = 0; k < F; k++) begin : g_root
    localparam logic [30:0] RootVal = cgc_pkg::exp_root(k + 1);
    assign root_tab[k] = RootVal;
  end

  logic [31:0] energy;
  logic [31:0] tracked;
  logic [16:0] lcoef;
  logic [48:0] lprod;
  logic [31:0] rad;
  logic [17:0] rem;
  logic [15:0] amp;
  logic [1:0]  region;
  logic [15:0] den;
  logic [14:0] ratio;
  logic [30:0] m;
  logic [LR-1:0] lg, ln;
  logic signed [NW-1:0] n;
  logic [F-1:0] frac;
  logic [30:0] mant;
  logic [46:0] val;
  logic [15:0] rg;
  logic [15:0] sg;
  logic [16:0] gcoef;
  logic [32:0] gprod;

  // Level smoother coefficient.
  logic [16:0] rise_c, fall_c, c_sel;
  always_comb begin
    if (energy > cgc_pkg::LOW_LEVEL_LIMIT) begin
      rise_c = cfg.level_rise_coef;
      fall_c = cfg.level_fall_coef;
    end else begin
      rise_c = cgc_pkg::LOW_RISE;
      fall_c = cgc_pkg::LOW_FALL;
    end
    c_sel = (energy > tracked) ? rise_c : fall_c;
    if (c_sel > cgc_pkg::ONE_Q16) c_sel = cgc_pkg::ONE_Q16;
  end

  logic [49:0] lsum;
  logic [31:0] tracked_next;
  assign lsum = 50'(lprod) + 50'(energy) * 50'(lcoef) + 50'd32768;
  assign tracked_next = lsum[47:16];

  // Square root, one result bit per step.
  logic [17:0] rem_sh, trial;
  assign rem_sh = {rem[15:0], rad[31:30]};
  assign trial = {amp, 2'b01};

  // Region selection and operands of the power law.
  logic [1:0]  reg_sel;
  logic [15:0] num_sel, den_sel;
  logic [14:0] ratio_sel;
  always_comb begin
    den_sel = cfg.lower_threshold;
    ratio_sel = cfg.lower_ratio;
    num_sel = amp;
    priority if (amp > cfg.upper_threshold) begin
      reg_sel = cgc_pkg::REGION_COMPRESS;
      den_sel = cfg.upper_threshold;
      ratio_sel = cfg.upper_ratio;
    end else if (cfg.conceal_level < amp && amp < cfg.lower_threshold) begin
      reg_sel = cgc_pkg::REGION_EXPAND;
    end else if (cfg.conceal_level <= amp) begin
      reg_sel = cgc_pkg::REGION_FLAT;
    end else begin
      reg_sel = cgc_pkg::REGION_CONCEAL;
      num_sel = cfg.conceal_level;
    end
    if (num_sel == 16'd0) num_sel = 16'd1;
    if (den_sel == 16'd0) den_sel = 16'd1;
  end

  // Log2 normalization of a 16-bit operand into a Q30 mantissa.
  logic [15:0] lx;
  logic [3:0]  lp;
  logic [4:0]  lsh;
  logic [30:0] m_init;
  assign lx = cmd.den_init ? den : num_sel;
  assign lp = cgc_pkg::msb16(lx);
  assign lsh = 5'd30 - {1'b0, lp};
  assign m_init = 31'({15'd0, lx} << lsh);

  logic [61:0] sq;
  logic [31:0] sq_t;
  assign sq = 62'(m) * 62'(m);
  assign sq_t = sq[61:30];

  // Power-law exponent.
  logic signed [DW-1:0] dlog;
  logic signed [15:0]   rdiff;
  logic signed [PW-1:0] eprod;
  assign dlog = $signed({1'b0, ln}) - $signed({1'b0, lg});
  assign rdiff = $signed({1'b0, ratio}) - 16'sd4096;
  assign eprod = PW'(dlog) * PW'(rdiff);

  logic [61:0] mprod;
  assign mprod = 62'(mant) * 62'(root_tab[cmd.idx[$clog2(F)-1:0]]);

  // Final scaling by 2^n with saturation.
  logic signed [10:0] s;
  logic [10:0]        sneg;
  logic [63:0]        r;
  logic [15:0]        pgain;
  always_comb begin
    s = 11'sd30 - 11'(n);
    sneg = 11'(-s);
    if (val == 47'd0) r = 64'd0;
    else if (s >= 11'sd64) r = 64'd0;
    else if (s >= 11'sd0) r = 64'(val) >> s[5:0];
    else if (s < -11'sd16) r = 64'd65535;
    else r = 64'(val) << sneg[4:0];
    pgain = (r > 64'd65535) ? 16'hFFFF : r[15:0];
  end

  logic [33:0] gsum;
  logic [17:0] gnew;
  logic [15:0] gsat;
  assign gsum = 34'(gprod) + 34'(rg) * 34'(gcoef) + 34'd32768;
  assign gnew = gsum[33:16];
  assign gsat = (gnew > 18'd65535) ? 16'hFFFF : gnew[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked <= 32'd0;
      sg <= cgc_pkg::GAIN_RESET;
    end else begin
      if (cmd.lvl_b) tracked <= tracked_next;
      if (cmd.gm_b) sg <= gsat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) energy <= energy_in;
    if (cmd.lvl_a) begin
      lcoef <= c_sel;
      lprod <= 49'(tracked) * 49'(cgc_pkg::ONE_Q16 - c_sel);
    end
    if (cmd.lvl_b) begin
      rad <= tracked_next;
      rem <= 18'd0;
      amp <= 16'd0;
    end
    if (cmd.sqrt_step) begin
      rad <= {rad[29:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        amp <= {amp[14:0], 1'b1};
      end else begin
        rem <= rem_sh;
        amp <= {amp[14:0], 1'b0};
      end
    end
    if (cmd.sel) begin
      region <= reg_sel;
      den <= den_sel;
      ratio <= ratio_sel;
    end
    if (cmd.sel || cmd.den_init) begin
      m <= m_init;
      lg <= LR'(lp);
    end
    if (cmd.den_init) ln <= lg;
    if (cmd.log_step) begin
      if (sq_t[31]) begin
        lg <= {lg[LR-2:0], 1'b1};
        m <= sq_t[31:1];
      end else begin
        lg <= {lg[LR-2:0], 1'b0};
        m <= sq_t[30:0];
      end
    end
    if (cmd.exp_init) begin
      n <= eprod[PW-1:12+F];
      frac <= eprod[12+F-1:12];
      mant <= 31'd1 << 30;
    end
    if (cmd.exp_step && frac[F-1-int'(cmd.idx)]) mant <= mprod[60:30];
    if (cmd.value) val <= 47'(cfg.moderate_gain) * 47'(mant);
    if (cmd.shift) rg <= (region == cgc_pkg::REGION_FLAT) ? cfg.moderate_gain : pgain;
    if (cmd.gm_a) begin
      gcoef <= (rg > sg) ? cgc_pkg::GAIN_RISE : cgc_pkg::GAIN_FALL;
      gprod <= 33'(sg) * 33'(cgc_pkg::ONE_Q16 -
               ((rg > sg) ? cgc_pkg::GAIN_RISE : cgc_pkg::GAIN_FALL));
    end
    if (cmd.gm_b) begin
      gain_out <= gsat;
      gain_region <= region;
    end
  end

endmodule

// ===== hdl/compandor_gain_computer_unit.sv =====
// Each transaction runs the 16-step square root and the three LOG_TABLE_BITS-step
// log/exp sequences one after another. s_tready is high only while idle, so the
// next energy value is not taken until the current result has been written; that
// final write waits while a previous result is still held unread on m_tdata.
// Reset (rst, synchronous, active high) clears the tracked energy, sets the
// smoothed gain to 4096 and loads the register defaults.
module compandor_gain_computer_unit #(
  parameter int LOG_TABLE_BITS = cgc_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // energy_in[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // gain_out[15:0]
  output logic [1:0]  m_tuser,   // gain_region[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  cgc_pkg::cfg_t cfg;
  cgc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_rise_coef <= 17'd6554;
      cfg.level_fall_coef <= 17'd655;
      cfg.upper_threshold <= 16'd16384;
      cfg.lower_threshold <= 16'd1024;
      cfg.upper_ratio     <= 15'd2048;
      cfg.lower_ratio     <= 15'd8192;
      cfg.conceal_level   <= 16'd64;
      cfg.moderate_gain   <= 16'd4096;
    end else if (cfg_valid) begin
      unique case (cgc_pkg::cfg_idx_t'(cfg_index))
        cgc_pkg::IDX_LEVEL_RISE:  cfg.level_rise_coef <= cfg_data;
        cgc_pkg::IDX_LEVEL_FALL:  cfg.level_fall_coef <= cfg_data;
        cgc_pkg::IDX_UPPER_THR:   cfg.upper_threshold <= cfg_data[15:0];
        cgc_pkg::IDX_LOWER_THR:   cfg.lower_threshold <= cfg_data[15:0];
        cgc_pkg::IDX_UPPER_RATIO: cfg.upper_ratio     <= cfg_data[14:0];
        cgc_pkg::IDX_LOWER_RATIO: cfg.lower_ratio     <= cfg_data[14:0];
        cgc_pkg::IDX_CONCEAL:     cfg.conceal_level   <= cfg_data[15:0];
        cgc_pkg::IDX_MOD_GAIN:    cfg.moderate_gain   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  cgc_controller #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  cgc_datapath #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .energy_in   (s_tdata),
    .gain_out    (m_tdata),
    .gain_region (m_tuser)
  );

endmodule
